/* rtl/cda_pkg.sv */
// Shared defaults and state codes for the Canberra distance accumulator.
package cda_pkg;

	localparam int ELEMENT_WIDTH_DEF      = 16;
	localparam int QUOTIENT_FRAC_BITS_DEF = 16;
	localparam int SUM_WIDTH_DEF          = 32;

	localparam int OUT_WIDTH = 32;

	localparam int ST_W = 2;
	localparam logic [ST_W-1:0] ST_IDLE = 2'd0;
	localparam logic [ST_W-1:0] ST_DIV  = 2'd1;
	localparam logic [ST_W-1:0] ST_ACC  = 2'd2;

endpackage

/* rtl/cda_divider.sv */
// Restoring divider, one quotient bit per cycle, for num <= den ratios.
module cda_divider #(
	parameter int ELEMENT_WIDTH      = cda_pkg::ELEMENT_WIDTH_DEF,
	parameter int QUOTIENT_FRAC_BITS = cda_pkg::QUOTIENT_FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ELEMENT_WIDTH:0]        num,
	input  logic [ELEMENT_WIDTH:0]        den,
	output logic [QUOTIENT_FRAC_BITS:0]   quot,
	output logic                          done
);

	localparam int MW = ELEMENT_WIDTH + 1;
	localparam int QW = QUOTIENT_FRAC_BITS + 1;
	localparam int CW = $clog2(QUOTIENT_FRAC_BITS);
	localparam logic [CW-1:0] CNT_LAST = CW'(QUOTIENT_FRAC_BITS - 1);

	logic [MW-1:0] rem_q;
	logic [MW-1:0] den_q;
	logic [QW-1:0] quot_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [MW:0]   rem_x2;
	logic [MW:0]   rem_sub;
	logic          step_ge;
	logic          init_ge;

	// num <= den, so the integer bit comes from one compare at start
	assign init_ge = (num >= den);
	assign rem_x2  = {rem_q, 1'b0};
	assign rem_sub = rem_x2 - {1'b0, den_q};
	assign step_ge = (rem_x2 >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q  <= den;
			rem_q  <= init_ge ? (num - den) : num;
			quot_q <= {{(QW-1){1'b0}}, init_ge};
		end else if (busy_q) begin
			rem_q  <= step_ge ? rem_sub[MW-1:0] : rem_x2[MW-1:0];
			quot_q <= {quot_q[QW-2:0], step_ge};
		end
	end

	assign quot = quot_q;
	assign done = done_q;

endmodule

/* rtl/canberra_distance_accumulator.sv */
// Canberra distance accumulator top level.
// An element pair goes from request through the serial divider, which makes one
// quotient bit a cycle, and the accumulate state to the sum update; in_stall
// holds off the next pair until then. A result on a last pair waits in the output
// register while the next pair is taken.
// Reset clears the running sum, the overflow flag and all handshake state.
module canberra_distance_accumulator #(
	parameter int ELEMENT_WIDTH      = cda_pkg::ELEMENT_WIDTH_DEF,
	parameter int QUOTIENT_FRAC_BITS = cda_pkg::QUOTIENT_FRAC_BITS_DEF,
	parameter int SUM_WIDTH          = cda_pkg::SUM_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [ELEMENT_WIDTH-1:0]   a_value,
	input  logic signed [ELEMENT_WIDTH-1:0]   b_value,
	input  logic                              last,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [cda_pkg::OUT_WIDTH-1:0]     distance,
	output logic                              saturated
);

	localparam int MW = ELEMENT_WIDTH + 1;
	localparam int QW = QUOTIENT_FRAC_BITS + 1;
	localparam int OW = cda_pkg::OUT_WIDTH;
	localparam int DW = (SUM_WIDTH > OW) ? SUM_WIDTH : OW;

	logic [cda_pkg::ST_W-1:0] state_q;
	logic [SUM_WIDTH-1:0]     sum_q;
	logic                     ovf_q;
	logic                     last_q;
	logic                     den_zero_q;
	logic                     out_valid_q;
	logic [OW-1:0]            distance_q;
	logic                     saturated_q;

	logic                     accept;
	logic signed [MW-1:0]     a_ext;
	logic signed [MW-1:0]     b_ext;
	logic signed [MW-1:0]     diff;
	logic [MW-1:0]            num;
	logic [MW-1:0]            mag_a;
	logic [MW-1:0]            mag_b;
	logic [MW-1:0]            den;
	logic [QW-1:0]            quot;
	logic                     div_done;

	logic [SUM_WIDTH:0]       sum_add;
	logic [SUM_WIDTH-1:0]     sum_fin;
	logic                     ovf_fin;
	logic [DW-1:0]            sum_ext;
	logic                     hi_nz;
	logic                     acc_go;

	assign in_stall = (state_q != cda_pkg::ST_IDLE);
	assign accept   = in_valid && !in_stall;

	assign a_ext = MW'(a_value);
	assign b_ext = MW'(b_value);
	assign diff  = a_ext - b_ext;
	assign num   = diff[MW-1]  ? MW'(-diff)  : MW'(diff);
	assign mag_a = a_ext[MW-1] ? MW'(-a_ext) : MW'(a_ext);
	assign mag_b = b_ext[MW-1] ? MW'(-b_ext) : MW'(b_ext);
	assign den   = mag_a + mag_b;

	cda_divider #(
		.ELEMENT_WIDTH      (ELEMENT_WIDTH),
		.QUOTIENT_FRAC_BITS (QUOTIENT_FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.num    (num),
		.den    (den),
		.quot   (quot),
		.done   (div_done)
	);

	// saturating accumulate; a zero denominator adds nothing
	always_comb begin
		sum_add = {1'b0, sum_q} + (SUM_WIDTH+1)'(quot);
		sum_fin = sum_q;
		ovf_fin = ovf_q;
		if (!den_zero_q) begin
			if (sum_add[SUM_WIDTH]) begin
				sum_fin = '1;
				ovf_fin = 1'b1;
			end else begin
				sum_fin = sum_add[SUM_WIDTH-1:0];
			end
		end
		sum_ext = DW'(sum_fin);
		hi_nz   = |(sum_ext >> OW);
	end

	// a last pair waits until the output register is free
	assign acc_go = (state_q == cda_pkg::ST_ACC) && !(last_q && out_valid_q && out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cda_pkg::ST_IDLE;
			sum_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (acc_go && last_q) || (out_valid_q && out_stall);
			case (state_q)
				cda_pkg::ST_IDLE: begin
					if (accept)
						state_q <= cda_pkg::ST_DIV;
				end
				cda_pkg::ST_DIV: begin
					if (div_done)
						state_q <= cda_pkg::ST_ACC;
				end
				cda_pkg::ST_ACC: begin
					if (acc_go) begin
						state_q <= cda_pkg::ST_IDLE;
						if (last_q) begin
							sum_q <= '0;
							ovf_q <= 1'b0;
						end else begin
							sum_q <= sum_fin;
							ovf_q <= ovf_fin;
						end
					end
				end
				default: state_q <= cda_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_q     <= last;
			den_zero_q <= (den == '0);
		end
		if (acc_go && last_q) begin
			distance_q  <= hi_nz ? {OW{1'b1}} : sum_ext[OW-1:0];
			saturated_q <= ovf_fin | hi_nz;
		end
	end

	assign out_valid = out_valid_q;
	assign distance  = distance_q;
	assign saturated = saturated_q;

endmodule
